FILE: sv/vpce_pkg.sv
// Shared types, codes and saturation helpers for the particle constraint engine.
// No dependencies; every other file imports this package.
package vpce_pkg;

  localparam int POS_W  = 32;
  localparam int IM_W   = 24;
  localparam int DAMP_W = 17;
  localparam int GRAV_W = 18;
  localparam int REST_W = 31;
  localparam int STIF_W = 17;
  localparam int IDX_W  = 10;
  localparam int SIG_W  = 66;
  localparam int SQ_IN_W  = 63;
  localparam int SQ_OUT_W = 32;
  localparam int DV_N_W   = 50;
  localparam int DV_D_W   = 33;
  localparam int WBITS    = 16;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_INTEG = 2'd1,
    MODE_JOINT = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_PINNED = 2'd1;
  localparam logic [1:0] STAT_SKIP   = 2'd2;
  localparam logic [1:0] STAT_SAT    = 2'd3;

  localparam logic CFG_DAMPING = 1'b0;
  localparam logic CFG_GRAVITY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_DISPATCH, S_ISUM, S_JSQ, S_JROOT, S_JDIV,
    S_JT, S_JC, S_JWA, S_JWB, S_DONE
  } state_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] prv_x;
    logic signed [POS_W-1:0] prv_y;
    logic        [IM_W-1:0]  im;
  } particle_t;

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [SIG_W-1:0] v);
    logic signed [SIG_W-1:0] hi;
    logic signed [SIG_W-1:0] lo;
    hi = SIG_W'(64'sh7FFF_FFFF);
    lo = -SIG_W'(64'sh8000_0000);
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return v[POS_W-1:0];
  endfunction

  function automatic logic ovf32(input logic signed [SIG_W-1:0] v);
    logic signed [SIG_W-1:0] hi;
    logic signed [SIG_W-1:0] lo;
    hi = SIG_W'(64'sh7FFF_FFFF);
    lo = -SIG_W'(64'sh8000_0000);
    return (v > hi) || (v < lo);
  endfunction

endpackage

FILE: sv/vpce_mem.sv
// Particle store: one write port, two registered read ports.
// Depends on vpce_pkg for the entry layout.
module vpce_mem import vpce_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  particle_t     wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output particle_t     rdata_a,
  output particle_t     rdata_b
);

  particle_t mem_r [DEPTH];
  particle_t rdata_a_r;
  particle_t rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

FILE: sv/vpce_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on vpce_pkg for widths.
module vpce_sqrt import vpce_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SQ_IN_W-1:0]  n,
  output logic                done,
  output logic [SQ_OUT_W-1:0] root
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] n_r;
  logic [63:0] r_r;
  logic [63:0] bit_r;
  logic [63:0] trial;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= {1'b0, n};
      r_r   <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (n_r >= trial) begin
        n_r <= n_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[SQ_OUT_W-1:0];

endmodule

FILE: sv/vpce_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on vpce_pkg for widths.
module vpce_div import vpce_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DV_N_W-1:0] dividend,
  input  logic [DV_D_W-1:0] divisor,
  output logic              done,
  output logic [DV_N_W-1:0] quot
);

  logic              busy_r;
  logic              done_r;
  logic [5:0]        cnt_r;
  logic [DV_N_W-1:0] dvd_r;
  logic [DV_N_W-1:0] quot_r;
  logic [DV_D_W-1:0] dvs_r;
  logic [DV_D_W-1:0] rem_r;
  logic [DV_D_W:0]   trial;
  logic              fits;

  assign trial = {rem_r, dvd_r[DV_N_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(DV_N_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      dvs_r  <= divisor;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      dvd_r  <= {dvd_r[DV_N_W-2:0], 1'b0};
      quot_r <= {quot_r[DV_N_W-2:0], fits};
      rem_r  <= fits ? DV_D_W'(trial - {1'b0, dvs_r}) : trial[DV_D_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

FILE: sv/verlet_particle_constraint_engine_core.sv
// Top level: request sequencer, fixed-point datapath and configuration registers.
// Depends on vpce_pkg, vpce_mem, vpce_sqrt and vpce_div.
//
//   channel | direction | handshake           | payload
//   in_     | request   | in_valid / in_stall | mode, indexes, values, mass, joint
//   out_    | result    | out_valid/out_stall | positions, velocity, status
//   cfg_    | write     | cfg_we              | cfg_index, cfg_data
//
// One request is in work at a time. A joint waits on the 32-step root unit and then
// the 50-step divider; a skipped joint or a pinned particle takes the same short path
// as a write or a read.
// rst_n is synchronous; the particle store is not cleared and holds garbage until
// written. A stalled result stays in the output register while the next request works.
module verlet_particle_constraint_engine_core import vpce_pkg::*; #(
  parameter int PARTICLES = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_mode,
  input  logic [IDX_W-1:0]         in_index_a,
  input  logic [IDX_W-1:0]         in_index_b,
  input  logic signed [POS_W-1:0]  in_value_x,
  input  logic signed [POS_W-1:0]  in_value_y,
  input  logic signed [POS_W-1:0]  in_vel_x,
  input  logic signed [POS_W-1:0]  in_vel_y,
  input  logic [IM_W-1:0]          in_inv_mass,
  input  logic [REST_W-1:0]        in_rest_length,
  input  logic [STIF_W-1:0]        in_stiffness_a,
  input  logic [STIF_W-1:0]        in_stiffness_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [POS_W-1:0]  out_pos_a_x,
  output logic signed [POS_W-1:0]  out_pos_a_y,
  output logic signed [POS_W-1:0]  out_pos_b_x,
  output logic signed [POS_W-1:0]  out_pos_b_y,
  output logic signed [POS_W-1:0]  out_vel_a_x,
  output logic signed [POS_W-1:0]  out_vel_a_y,
  output logic [1:0]               out_status,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [GRAV_W-1:0]        cfg_data
);

  localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int unsigned RECIP = ((2 ** 21) + PARTICLES - 1) / PARTICLES;

  function automatic logic [AW-1:0] idx_mod(input logic [IDX_W-1:0] idx);
    logic [31:0] q;
    logic [31:0] r;
    q = (32'(idx) * 32'(RECIP)) >> 21;
    r = 32'(idx) - q * 32'(PARTICLES);
    return r[AW-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [DAMP_W-1:0]        damping_r;
  logic signed [GRAV_W-1:0] gravity_r;

  mode_t                    mode_r;
  logic [AW-1:0]            a_r, b_r;
  logic signed [POS_W-1:0]  vx_r, vy_r, wx_r, wy_r;
  logic [IM_W-1:0]          im_r;
  logic [REST_W-1:0]        rest_r;
  logic [STIF_W-1:0]        sa_r, sb_r;

  logic signed [POS_W-1:0]  rpa_x_r, rpa_y_r, rpb_x_r, rpb_y_r, rprv_x_r, rprv_y_r;
  logic                     sat_r;
  logic [1:0]               stat_r;

  logic signed [50:0] p1x_r, p1y_r;
  logic signed [49:0] p2x_r, p2y_r;
  logic signed [57:0] p3x_r, p3y_r;

  logic signed [32:0] dx_r, dy_r;
  logic [30:0]        ux_r, uy_r;
  logic               s_r;
  logic               neg_r;
  logic signed [31:0] q_r;
  logic signed [48:0] tx_r, ty_r;
  logic signed [66:0] cax_r, cay_r, cbx_r, cby_r;

  logic                     out_valid_r;
  logic signed [POS_W-1:0]  o_pax_r, o_pay_r, o_pbx_r, o_pby_r, o_vx_r, o_vy_r;
  logic [1:0]               o_stat_r;

  particle_t ent_a, ent_b, mem_wdata;
  logic      mem_we, mem_re;
  logic [AW-1:0] mem_waddr;

  logic                 sq_start, sq_done;
  logic [SQ_OUT_W-1:0]  sq_root;
  logic [SQ_IN_W-1:0]   sq_n;
  logic                 dv_start, dv_done;
  logic [DV_N_W-1:0]    dv_quot, dv_dvd;
  logic [DV_D_W-1:0]    dv_len;

  // write request
  logic signed [SIG_W-1:0] wdx, wdy;
  logic signed [POS_W-1:0] wprv_x, wprv_y;
  // integrate
  logic [17:0]             opd;
  logic signed [18:0]      opd_s;
  logic signed [17:0]      d_s;
  logic signed [24:0]      m_s;
  logic signed [32:0]      fx, fy;
  logic signed [50:0]      p1x, p1y;
  logic signed [49:0]      p2x, p2y;
  logic signed [57:0]      p3x, p3y;
  logic signed [59:0]      sumx, sumy, shx, shy;
  logic signed [POS_W-1:0] inx, iny;
  logic                    iovf;
  // joint
  logic signed [32:0]      dx, dy;
  logic [32:0]             ux, uy;
  logic                    big, dzero;
  logic [61:0]             sqx, sqy;
  logic signed [33:0]      num;
  logic [33:0]             nmag;
  logic                    qbig;
  logic [30:0]             qm;
  logic signed [64:0]      tpx, tpy;
  logic signed [17:0]      sa_s, sb_s;
  logic signed [66:0]      cpax, cpay, cpbx, cpby;
  logic signed [49:0]      cax, cay, cbx, cby;
  logic signed [SIG_W-1:0] nax_w, nay_w, nbx_w, nby_w;
  logic signed [POS_W-1:0] nax, nay, nbx, nby;
  logic                    jovf;
  // result
  logic signed [SIG_W-1:0] vdx, vdy;
  logic                    vovf;
  logic                    out_free;

  vpce_mem #(.DEPTH(PARTICLES), .AW(AW)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (a_r),
    .raddr_b (b_r),
    .rdata_a (ent_a),
    .rdata_b (ent_b)
  );

  vpce_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .n     (sq_n),
    .done  (sq_done),
    .root  (sq_root)
  );

  vpce_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_dvd),
    .divisor  (dv_len),
    .done     (dv_done),
    .quot     (dv_quot)
  );

  always_comb begin
    wdx    = SIG_W'(vx_r) - SIG_W'(wx_r);
    wdy    = SIG_W'(vy_r) - SIG_W'(wy_r);
    wprv_x = sat32(wdx);
    wprv_y = sat32(wdy);

    opd   = {1'b0, damping_r} + 18'd65536;
    opd_s = signed'({1'b0, opd});
    d_s   = signed'({1'b0, damping_r});
    m_s   = signed'({1'b0, ent_a.im});
    fx    = 33'(vx_r);
    fy    = 33'(vy_r) + 33'(gravity_r);
    p1x   = ent_a.pos_x * opd_s;
    p1y   = ent_a.pos_y * opd_s;
    p2x   = ent_a.prv_x * d_s;
    p2y   = ent_a.prv_y * d_s;
    p3x   = fx * m_s;
    p3y   = fy * m_s;
    sumx  = 60'(p1x_r) - 60'(p2x_r) + 60'(p3x_r);
    sumy  = 60'(p1y_r) - 60'(p2y_r) + 60'(p3y_r);
    shx   = sumx >>> WBITS;
    shy   = sumy >>> WBITS;
    inx   = sat32(SIG_W'(shx));
    iny   = sat32(SIG_W'(shy));
    iovf  = ovf32(SIG_W'(shx)) || ovf32(SIG_W'(shy));

    dx    = 33'(ent_b.pos_x) - 33'(ent_a.pos_x);
    dy    = 33'(ent_b.pos_y) - 33'(ent_a.pos_y);
    dzero = (dx == '0) && (dy == '0);
    ux    = dx[32] ? 33'(-dx) : 33'(dx);
    uy    = dy[32] ? 33'(-dy) : 33'(dy);
    big   = ux[32] | ux[31] | uy[32] | uy[31];
    sqx   = ux_r * ux_r;
    sqy   = uy_r * uy_r;
    sq_n  = {1'b0, sqx} + {1'b0, sqy};

    dv_len = s_r ? {sq_root, 1'b0} : {1'b0, sq_root};
    num    = signed'({1'b0, dv_len}) - signed'({3'b0, rest_r});
    nmag   = num[33] ? 34'(-num) : 34'(num);
    dv_dvd = {nmag, 16'b0};
    qbig   = dv_quot > DV_N_W'(2 ** 30);
    qm     = qbig ? 31'(2 ** 30) : dv_quot[30:0];

    tpx  = dx_r * q_r;
    tpy  = dy_r * q_r;
    sa_s = signed'({1'b0, sa_r});
    sb_s = signed'({1'b0, sb_r});
    cpax = tx_r * sa_s;
    cpay = ty_r * sa_s;
    cpbx = tx_r * sb_s;
    cpby = ty_r * sb_s;
    cax  = 50'(cax_r >>> (WBITS + 1));
    cay  = 50'(cay_r >>> (WBITS + 1));
    cbx  = 50'(cbx_r >>> (WBITS + 1));
    cby  = 50'(cby_r >>> (WBITS + 1));
    nax_w = SIG_W'(ent_a.pos_x) + SIG_W'(cax);
    nay_w = SIG_W'(ent_a.pos_y) + SIG_W'(cay);
    nbx_w = SIG_W'(ent_b.pos_x) - SIG_W'(cbx);
    nby_w = SIG_W'(ent_b.pos_y) - SIG_W'(cby);
    nax   = sat32(nax_w);
    nay   = sat32(nay_w);
    nbx   = sat32(nbx_w);
    nby   = sat32(nby_w);
    jovf  = ovf32(nax_w) || ovf32(nay_w) || ovf32(nbx_w) || ovf32(nby_w);

    vdx  = SIG_W'(rpa_x_r) - SIG_W'(rprv_x_r);
    vdy  = SIG_W'(rpa_y_r) - SIG_W'(rprv_y_r);
    vovf = ovf32(vdx) || ovf32(vdy);
    out_free = !out_valid_r || !out_stall;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_FETCH;
      S_FETCH:    state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        case (mode_r)
          MODE_INTEG: state_nxt = (ent_a.im == '0) ? S_DONE : S_ISUM;
          MODE_JOINT: state_nxt = dzero ? S_DONE : S_JSQ;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_ISUM:  state_nxt = S_DONE;
      S_JSQ:   state_nxt = S_JROOT;
      S_JROOT: if (sq_done) state_nxt = S_JDIV;
      S_JDIV:  if (dv_done) state_nxt = S_JT;
      S_JT:    state_nxt = S_JC;
      S_JC:    state_nxt = S_JWA;
      S_JWA:   state_nxt = S_JWB;
      S_JWB:   state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = a_r;
    mem_wdata = '0;
    mem_re    = (state_r == S_FETCH);
    sq_start  = (state_r == S_JSQ);
    dv_start  = (state_r == S_JROOT) && sq_done;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_DISPATCH: begin
        if (mode_r == MODE_WRITE) begin
          mem_we    = 1'b1;
          mem_wdata = '{pos_x: vx_r, pos_y: vy_r, prv_x: wprv_x, prv_y: wprv_y, im: im_r};
        end
      end
      S_ISUM: begin
        mem_we    = 1'b1;
        mem_wdata = '{pos_x: inx, pos_y: iny, prv_x: ent_a.pos_x, prv_y: ent_a.pos_y,
                      im: ent_a.im};
      end
      S_JWA: begin
        mem_we    = 1'b1;
        mem_wdata = '{pos_x: nax, pos_y: nay, prv_x: ent_a.prv_x, prv_y: ent_a.prv_y,
                      im: ent_a.im};
      end
      S_JWB: begin
        mem_we    = 1'b1;
        mem_waddr = b_r;
        mem_wdata = '{pos_x: rpb_x_r, pos_y: rpb_y_r, prv_x: ent_b.prv_x,
                      prv_y: ent_b.prv_y, im: ent_b.im};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      damping_r <= DAMP_W'(65470);
      gravity_r <= GRAV_W'(1966);
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DAMPING: damping_r <= cfg_data[DAMP_W-1:0];
          CFG_GRAVITY: gravity_r <= signed'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_r <= mode_t'(in_mode);
          a_r    <= idx_mod(in_index_a);
          b_r    <= idx_mod(in_index_b);
          vx_r   <= in_value_x;
          vy_r   <= in_value_y;
          wx_r   <= in_vel_x;
          wy_r   <= in_vel_y;
          im_r   <= in_inv_mass;
          rest_r <= in_rest_length;
          sa_r   <= in_stiffness_a;
          sb_r   <= in_stiffness_b;
        end
      end
      S_DISPATCH: begin
        case (mode_r)
          MODE_WRITE: begin
            sat_r    <= ovf32(wdx) || ovf32(wdy);
            stat_r   <= STAT_OK;
            rpb_x_r  <= '0;
            rpb_y_r  <= '0;
            rpa_x_r  <= vx_r;
            rpa_y_r  <= vy_r;
            rprv_x_r <= wprv_x;
            rprv_y_r <= wprv_y;
          end
          MODE_INTEG: begin
            sat_r    <= 1'b0;
            stat_r   <= (ent_a.im == '0) ? STAT_PINNED : STAT_OK;
            rpb_x_r  <= '0;
            rpb_y_r  <= '0;
            rpa_x_r  <= ent_a.pos_x;
            rpa_y_r  <= ent_a.pos_y;
            rprv_x_r <= ent_a.prv_x;
            rprv_y_r <= ent_a.prv_y;
            p1x_r    <= p1x;
            p1y_r    <= p1y;
            p2x_r    <= p2x;
            p2y_r    <= p2y;
            p3x_r    <= p3x;
            p3y_r    <= p3y;
          end
          MODE_JOINT: begin
            sat_r    <= 1'b0;
            stat_r   <= dzero ? STAT_SKIP : STAT_OK;
            rpb_x_r  <= ent_b.pos_x;
            rpb_y_r  <= ent_b.pos_y;
            rpa_x_r  <= ent_a.pos_x;
            rpa_y_r  <= ent_a.pos_y;
            rprv_x_r <= ent_a.prv_x;
            rprv_y_r <= ent_a.prv_y;
            dx_r     <= dx;
            dy_r     <= dy;
            s_r      <= big;
            ux_r     <= big ? ux[31:1] : ux[30:0];
            uy_r     <= big ? uy[31:1] : uy[30:0];
          end
          default: begin
            sat_r    <= 1'b0;
            stat_r   <= STAT_OK;
            rpb_x_r  <= '0;
            rpb_y_r  <= '0;
            rpa_x_r  <= ent_a.pos_x;
            rpa_y_r  <= ent_a.pos_y;
            rprv_x_r <= ent_a.prv_x;
            rprv_y_r <= ent_a.prv_y;
          end
        endcase
      end
      S_ISUM: begin
        rpa_x_r  <= inx;
        rpa_y_r  <= iny;
        rprv_x_r <= ent_a.pos_x;
        rprv_y_r <= ent_a.pos_y;
        sat_r    <= iovf;
      end
      S_JROOT: begin
        if (sq_done) neg_r <= num[33];
      end
      S_JDIV: begin
        if (dv_done) begin
          q_r   <= neg_r ? -signed'({1'b0, qm}) : signed'({1'b0, qm});
          sat_r <= qbig;
        end
      end
      S_JT: begin
        tx_r <= 49'(tpx >>> WBITS);
        ty_r <= 49'(tpy >>> WBITS);
      end
      S_JC: begin
        cax_r <= cpax;
        cay_r <= cpay;
        cbx_r <= cpbx;
        cby_r <= cpby;
      end
      S_JWA: begin
        rpa_x_r <= nax;
        rpa_y_r <= nay;
        rpb_x_r <= nbx;
        rpb_y_r <= nby;
        sat_r   <= sat_r || jovf;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      o_pax_r  <= rpa_x_r;
      o_pay_r  <= rpa_y_r;
      o_pbx_r  <= rpb_x_r;
      o_pby_r  <= rpb_y_r;
      o_vx_r   <= sat32(vdx);
      o_vy_r   <= sat32(vdy);
      o_stat_r <= (stat_r == STAT_OK && (sat_r || vovf)) ? STAT_SAT : stat_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pos_a_x = o_pax_r;
  assign out_pos_a_y = o_pay_r;
  assign out_pos_b_x = o_pbx_r;
  assign out_pos_b_y = o_pby_r;
  assign out_vel_a_x = o_vx_r;
  assign out_vel_a_y = o_vy_r;
  assign out_status  = o_stat_r;

endmodule

FILE: bench/tb_verlet_particle_constraint_engine_core.sv
// Self-checking bench for the particle constraint engine: a directed table, then random
// requests across four idle/stall phases and several register settings.
// Depends on vpce_pkg and the verlet_particle_constraint_engine_core RTL.
`timescale 1ns / 1ps

module tb_verlet_particle_constraint_engine_core;
  import vpce_pkg::*;

  typedef struct {
    logic [1:0]  mode;
    logic [9:0]  ia;
    logic [9:0]  ib;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] wx;
    logic [31:0] wy;
    logic [23:0] im;
    logic [30:0] rest;
    logic [16:0] sa;
    logic [16:0] sb;
  } req_t;

  typedef struct {
    logic [31:0] pax;
    logic [31:0] pay;
    logic [31:0] pbx;
    logic [31:0] pby;
    logic [31:0] vax;
    logic [31:0] vay;
    logic [1:0]  st;
  } res_t;

  typedef struct {
    req_t r;
    bit   chk;
    res_t e;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = '0;
  logic [IDX_W-1:0] in_index_a = '0, in_index_b = '0;
  logic signed [POS_W-1:0] in_value_x = '0, in_value_y = '0, in_vel_x = '0, in_vel_y = '0;
  logic [IM_W-1:0] in_inv_mass = '0;
  logic [REST_W-1:0] in_rest_length = '0;
  logic [STIF_W-1:0] in_stiffness_a = '0, in_stiffness_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [POS_W-1:0] out_pos_a_x, out_pos_a_y, out_pos_b_x, out_pos_b_y;
  logic signed [POS_W-1:0] out_vel_a_x, out_vel_a_y;
  logic [1:0] out_status;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_DAMPING;
  logic [GRAV_W-1:0] cfg_data = '0;

  verlet_particle_constraint_engine_core dut (.*);

  always #6 clk = ~clk;

  // particle store mirror and register copies
  longint px_m[1024], py_m[1024], qx_m[1024], qy_m[1024];
  longint im_m[1024];
  bit     loaded[1024];
  longint damp_r = 65470, grav_r = 1966;

  res_t   pending[$];
  row_t   rows[$];
  int     errors = 0, n_sent = 0, n_got = 0, n_joint = 0, idle_cnt = 0;
  int     gap_pct = 0, stall_pct = 0;
  bit     accepted_in = 0;
  int     pool[24];

  function automatic longint sat_to32(longint v, ref bit s);
    if (v > 64'sd2147483647) begin
      s = 1; return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      s = 1; return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic res_t particle_step(req_t r);
    res_t   o;
    bit     s;
    int     a, b;
    longint vx, vy, wx, wy, ax, ay, bx, by, dx, dy, nx, ny, len, q, tx, ty, lim;
    longint unsigned ux, uy;
    int     sh;
    s = 0; a = int'(r.ia); b = int'(r.ib);
    vx = longint'($signed(r.vx)); vy = longint'($signed(r.vy));
    wx = longint'($signed(r.wx)); wy = longint'($signed(r.wy));
    o = '{default: '0};
    case (r.mode)
      MODE_WRITE: begin
        px_m[a] = vx; py_m[a] = vy;
        qx_m[a] = sat_to32(vx - wx, s);
        qy_m[a] = sat_to32(vy - wy, s);
        im_m[a] = longint'(r.im); loaded[a] = 1;
      end
      MODE_INTEG: begin
        if (im_m[a] == 0) o.st = STAT_PINNED;
        else begin
          nx = px_m[a] * (65536 + damp_r) - qx_m[a] * damp_r + vx * im_m[a];
          ny = py_m[a] * (65536 + damp_r) - qy_m[a] * damp_r + (vy + grav_r) * im_m[a];
          qx_m[a] = px_m[a]; qy_m[a] = py_m[a];
          px_m[a] = sat_to32(nx >>> 16, s);
          py_m[a] = sat_to32(ny >>> 16, s);
        end
      end
      MODE_JOINT: begin
        ax = px_m[a]; ay = py_m[a]; bx = px_m[b]; by = py_m[b];
        dx = bx - ax; dy = by - ay;
        if (dx == 0 && dy == 0) o.st = STAT_SKIP;
        else begin
          ux = dx < 0 ? -dx : dx;
          uy = dy < 0 ? -dy : dy;
          sh = 0;
          if (ux >= 64'd2147483648 || uy >= 64'd2147483648) begin
            sh = 1; ux >>= 1; uy >>= 1;
          end
          len = longint'(root64(ux * ux + uy * uy) << sh);
          q = (len - longint'(r.rest)) * 65536 / len;
          lim = 64'sd1 << 30;
          if (q > lim) begin
            q = lim; s = 1;
          end
          if (q < -lim) begin
            q = -lim; s = 1;
          end
          tx = (dx * q) >>> 16;
          ty = (dy * q) >>> 16;
          px_m[a] = sat_to32(ax + ((tx * longint'(r.sa)) >>> 17), s);
          py_m[a] = sat_to32(ay + ((ty * longint'(r.sa)) >>> 17), s);
          px_m[b] = sat_to32(bx - ((tx * longint'(r.sb)) >>> 17), s);
          py_m[b] = sat_to32(by - ((ty * longint'(r.sb)) >>> 17), s);
        end
        o.pbx = 32'(px_m[b]); o.pby = 32'(py_m[b]);
      end
      default: ;
    endcase
    o.pax = 32'(px_m[a]); o.pay = 32'(py_m[a]);
    o.vax = 32'(sat_to32(px_m[a] - qx_m[a], s));
    o.vay = 32'(sat_to32(py_m[a] - qy_m[a], s));
    if (o.st == STAT_OK && s) o.st = STAT_SAT;
    return o;
  endfunction

  task automatic add_row(logic [1:0] m, int ia, int ib, logic [31:0] vx, logic [31:0] vy,
                         logic [31:0] wx, logic [31:0] wy, logic [23:0] im,
                         logic [30:0] rest, logic [16:0] sa, logic [16:0] sb,
                         bit chk = 0, res_t e = '{default: '0});
    row_t w;
    w.r = '{m, 10'(ia), 10'(ib), vx, vy, wx, wy, im, rest, sa, sb};
    w.chk = chk; w.e = e;
    rows.insert(rows.size(), w);
  endtask

  task automatic send_request(req_t r, bit chk = 0, res_t e = '{default: '0});
    res_t p;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_mode <= r.mode; in_index_a <= r.ia; in_index_b <= r.ib;
    in_value_x <= r.vx; in_value_y <= r.vy; in_vel_x <= r.wx; in_vel_y <= r.wy;
    in_inv_mass <= r.im; in_rest_length <= r.rest;
    in_stiffness_a <= r.sa; in_stiffness_b <= r.sb;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = particle_step(r);
    pending.insert(pending.size(), chk ? e : p);
    n_sent++;
    if (r.mode == MODE_JOINT) n_joint++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [GRAV_W-1:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DAMPING) damp_r = longint'(v[16:0]);
    else grav_r = longint'($signed(v));
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed($urandom_range(1 << 22)) - (1 << 21);
    endcase
  endfunction

  function automatic int pick_loaded();
    int k;
    k = pool[$urandom_range(23)];
    return loaded[k] ? k : -1;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   a, b, roll;
    r.ib = 10'($urandom); r.vx = rand_pos(); r.vy = rand_pos();
    r.wx = $urandom_range(3) == 0 ? $urandom : $signed($urandom_range(1 << 18)) - (1 << 17);
    r.wy = $urandom_range(3) == 0 ? $urandom : $signed($urandom_range(1 << 18)) - (1 << 17);
    r.im = $urandom_range(5) == 0 ? 24'd0 :
           ($urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(1 << 17)));
    r.rest = $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(1 << 22));
    r.sa = $urandom_range(4) == 0 ? 17'd65536 : 17'($urandom_range(65536));
    r.sb = $urandom_range(4) == 0 ? 17'd65536 : 17'($urandom_range(65536));
    a = pick_loaded();
    roll = $urandom_range(99);
    if (a < 0 || roll < 20) begin
      r.mode = MODE_WRITE;
      r.ia = $urandom_range(9) == 0 ? 10'($urandom) : 10'(pool[$urandom_range(23)]);
    end else if (roll < 50) begin
      r.mode = MODE_INTEG; r.ia = 10'(a);
    end else if (roll < 80) begin
      b = pick_loaded();
      r.mode = MODE_JOINT; r.ia = 10'(a);
      r.ib = (b < 0 || $urandom_range(19) == 0) ? 10'(a) : 10'(b);
    end else begin
      r.mode = MODE_READ; r.ia = 10'(a);
    end
    return r;
  endfunction

  task automatic cmp(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s expected %h got %h", name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    accepted_in = in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      n_got++;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = pending.pop_front();
        cmp("pos_a_x", e.pax, out_pos_a_x);
        cmp("pos_a_y", e.pay, out_pos_a_y);
        cmp("pos_b_x", e.pbx, out_pos_b_x);
        cmp("pos_b_y", e.pby, out_pos_b_y);
        cmp("vel_a_x", e.vax, out_vel_a_x);
        cmp("vel_a_y", e.vay, out_vel_a_y);
        cmp("status", 32'(e.st), 32'(out_status));
      end
    end
    if (accepted_in || (out_valid && !out_stall)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= 5000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= rst_n && ($urandom_range(99) < stall_pct);

  initial begin
    int gaps[4] = '{0, 67, 0, 22};
    int stalls[4] = '{0, 0, 67, 22};
    logic [17:0] damps[4] = '{18'd0, 18'd65536, 18'd65470, 18'd30000};
    logic [17:0] gravs[4] = '{-18'sd65536, 18'sd65536, 18'd0, 18'd1966};
    for (int i = 0; i < 1024; i++) begin
      px_m[i] = 0; py_m[i] = 0; qx_m[i] = 0; qy_m[i] = 0; im_m[i] = 0; loaded[i] = 0;
    end
    pool[0] = 0; pool[1] = 1023; pool[2] = 1; pool[3] = 2; pool[4] = 3; pool[5] = 5;
    for (int i = 6; i < 24; i++) pool[i] = $urandom_range(1023);

    add_row(MODE_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{default: '0});
    add_row(MODE_READ, 0, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{default: '0});
    add_row(MODE_INTEG, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
            '{0, 0, 0, 0, 0, 0, STAT_PINNED});
    add_row(MODE_JOINT, 0, 0, 0, 0, 0, 0, 0, 0, 17'd65536, 17'd65536, 1,
            '{0, 0, 0, 0, 0, 0, STAT_SKIP});
    add_row(MODE_WRITE, 1023, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 24'hFF_FFFF, 0, 0, 0,
            1, '{32'h7FFF_FFFF, 0, 0, 0, 0, 0, STAT_SAT});
    add_row(MODE_READ, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
            '{32'h7FFF_FFFF, 0, 0, 0, 0, 0, STAT_OK});
    add_row(MODE_WRITE, 5, 0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            1, 0, 0, 0);
    add_row(MODE_JOINT, 1023, 5, 0, 0, 0, 0, 0, 0, 17'd65536, 17'd65536);
    add_row(MODE_WRITE, 1, 0, 32'h1_0000, 0, 0, 0, 24'h1_0000, 0, 0, 0);
    add_row(MODE_WRITE, 2, 0, 32'h3_0000, 0, 32'h100, -32'sh100, 24'h1_0000, 0, 0, 0);
    add_row(MODE_JOINT, 1, 2, 0, 0, 0, 0, 0, 31'h7FFF_FFFF, 17'd65536, 0);
    add_row(MODE_INTEG, 2, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
    add_row(MODE_INTEG, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_JOINT, 1, 2, 0, 0, 0, 0, 0, 31'h2_0000, 17'h8000, 17'h8000);
    add_row(MODE_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_READ, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_WRITE, 3, 0, 32'h8000_0000, 0, 1, 0, 24'h00_0001, 0, 0, 0,
            1, '{32'h8000_0000, 0, 0, 0, 0, 0, STAT_SAT});
    add_row(MODE_JOINT, 3, 1023, 0, 0, 0, 0, 0, 31'h7FFF_FFFF, 17'd65536, 17'd65536);
    add_row(MODE_INTEG, 5, 0, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
    add_row(MODE_READ, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_request(rows[i].r, rows[i].chk, rows[i].e);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_DAMPING, damps[ph]);
      write_reg(CFG_GRAVITY, gravs[ph]);
      gap_pct = gaps[ph]; stall_pct = stalls[ph];
      for (int k = 0; k < 250; k++) begin
        send_request(random_request());
        if (k == 125) begin
          in_valid <= 1'b0;
          @(negedge clk);
          while (pending.size() != 0) @(negedge clk);
        end
      end
      drain();
    end
    stall_pct = 0;
    drain();

    $display("covered %0d requests (%0d joints), %0d results, 4 idle phases, 4 settings",
             n_sent, n_joint, n_got);
    if (errors == 0 && pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
